>>> hw/rtl/chd_pkg.sv
package chd_pkg;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  // Line control characters.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Largest size value before the gathered size saturates.
  localparam logic [31:0] SIZE_SAT_LIMIT = 32'h0FFF_FFFF;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] nib;
  } chd_item_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic      not_empty;
    chd_item_t head;
  } chd_q_stat_t;

endpackage

>>> hw/rtl/chd_front.sv
module chd_front import chd_pkg::*; (
  input  logic [7:0] in_byte_i,
  output chd_item_t  item_o
);

  // Classify the byte: line characters and hex digit value.
  always_comb begin
    item_o.data   = in_byte_i;
    item_o.is_cr  = (in_byte_i == CH_CR);
    item_o.is_lf  = (in_byte_i == CH_LF);
    item_o.is_hex = 1'b0;
    item_o.nib    = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      item_o.is_hex = 1'b1;
      item_o.nib    = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      item_o.is_hex = 1'b1;
      item_o.nib    = 4'(in_byte_i - 8'h41 + 8'd10);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      item_o.is_hex = 1'b1;
      item_o.nib    = 4'(in_byte_i - 8'h61 + 8'd10);
    end
  end

endmodule

>>> hw/rtl/chd_queue.sv
module chd_queue import chd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  chd_item_t   item_i,
  output logic        full_o,
  input  logic        pop_i,
  output chd_q_stat_t stat_o
);

  chd_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o           = (count_q == 2'd2);
  assign stat_o.not_empty = (count_q != 2'd0);
  assign stat_o.head      = mem_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue occupancy out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 2'd1)
    else $error("queue occupancy did not grow on push");

endmodule

>>> hw/rtl/chd_back.sv
module chd_back import chd_pkg::*; #(
  parameter int MAX_SIZE_DIGITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chd_q_stat_t stat_i,
  output logic        pop_o,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic        body_done_o,
  output logic [1:0]  status_o
);

  localparam int LCW = $clog2(MAX_SIZE_DIGITS + 1);

  typedef enum logic [3:0] {
    PH_SIZE, PH_SIZE_LF, PH_DATA, PH_DATA_CR, PH_DATA_LF,
    PH_FIN_CR, PH_FIN_LF, PH_DONE, PH_FAIL
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [31:0]     size_q, size_d;
  logic [LCW-1:0]  chars_q, chars_d;
  logic            stop_q, stop_d;
  logic [31:0]     left_q, left_d;
  logic [1:0]      err_q, err_d;
  logic            vld_d;

  logic            res_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_valid_q;
  logic            done_q;
  logic [1:0]      status_q;

  chd_item_t       it;

  assign it    = stat_i.head;
  assign pop_o = stat_i.not_empty && (!res_valid_q || !res_stall_i);

  assign res_valid_o = res_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_valid_o = out_valid_q;
  assign body_done_o = done_q;
  assign status_o    = status_q;

  // One parser step for the byte at the head of the queue.
  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    chars_d = chars_q;
    stop_d  = stop_q;
    left_d  = left_q;
    err_d   = err_q;
    vld_d   = 1'b0;
    unique case (phase_q)
      PH_SIZE: begin
        if (it.is_cr) begin
          phase_d = PH_SIZE_LF;
        end else if (chars_q >= LCW'(MAX_SIZE_DIGITS)) begin
          err_d   = ST_LONG;
          phase_d = PH_FAIL;
        end else begin
          chars_d = chars_q + LCW'(1);
          if (!stop_q && it.is_hex) begin
            if (size_q > SIZE_SAT_LIMIT) begin
              size_d = '1;
            end else begin
              size_d = {size_q[27:0], it.nib};
            end
          end else begin
            stop_d = 1'b1;
          end
        end
      end
      PH_SIZE_LF: begin
        if (!it.is_lf) begin
          err_d   = ST_BAD;
          phase_d = PH_FAIL;
        end else if (size_q == 32'd0) begin
          phase_d = PH_FIN_CR;
        end else begin
          left_d  = size_q;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        vld_d = 1'b1;
        if (left_q != 32'd0) left_d = left_q - 32'd1;
        if (left_d == 32'd0) phase_d = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (it.is_cr) begin
          phase_d = PH_DATA_LF;
        end else begin
          err_d   = ST_BAD;
          phase_d = PH_FAIL;
        end
      end
      PH_DATA_LF: begin
        if (it.is_lf) begin
          size_d  = 32'd0;
          chars_d = '0;
          stop_d  = 1'b0;
          phase_d = PH_SIZE;
        end else begin
          err_d   = ST_BAD;
          phase_d = PH_FAIL;
        end
      end
      PH_FIN_CR: begin
        if (it.is_cr) begin
          phase_d = PH_FIN_LF;
        end else begin
          err_d   = ST_BAD;
          phase_d = PH_FAIL;
        end
      end
      PH_FIN_LF: begin
        if (it.is_lf) begin
          phase_d = PH_DONE;
        end else begin
          err_d   = ST_BAD;
          phase_d = PH_FAIL;
        end
      end
      PH_DONE: ;
      PH_FAIL: ;
      default: phase_d = PH_FAIL;
    endcase
  end

  // Parser state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      size_q      <= 32'd0;
      chars_q     <= '0;
      stop_q      <= 1'b0;
      left_q      <= 32'd0;
      err_q       <= ST_OK;
      res_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        size_q      <= size_d;
        chars_q     <= chars_d;
        stop_q      <= stop_d;
        left_q      <= left_d;
        err_q       <= err_d;
        res_valid_q <= 1'b1;
        out_byte_q  <= vld_d ? it.data : 8'd0;
        out_valid_q <= vld_d;
        done_q      <= (phase_d == PH_DONE);
        status_q    <= err_d;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK) |=> (err_q == $past(err_q)))
    else $error("error status changed after being set");
  a_done_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && status_q != ST_OK)) else $error("done together with an error");
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_q == ST_OK && !done_q))
    else $error("payload flagged outside body data");

endmodule

>>> hw/rtl/http_chunked_body_decoder_top.sv
// Chunked HTTP body decoder.
// Input channel: in_valid_i / in_stall_o carry one raw body byte (in_byte_i)
// per request. Output channel: res_valid_o / res_stall_i carry one result
// per input byte: out_byte_o and out_valid_o for payload bytes, body_done_o
// once the zero chunk and its final CR LF have arrived, and status_o
// (0 ok, 1 bad request, 2 size line too long).
// A request is taken at a rising edge with valid high and stall low.
// The front end classifies each byte into a two-entry queue; the back end
// runs the chunk parser one byte per cycle, while the receiver does not stall,
// into an output register. A taken byte is written into the queue and then
// popped through the parser into the output register. Throughput is one byte
// per cycle when not stalled, set by the single parser step per byte. When the
// receiver stalls, the result holds and the queue fills with up to two
// requests; in_stall_o then stays high until a result is taken.
// Reset empties the queue, clears the output register and returns the
// parser to the start of a size line with status ok.
// After done or an error, bytes are still taken and answered, and the
// status and done flag hold until reset.
module http_chunked_body_decoder_top import chd_pkg::*; #(
  parameter int MAX_SIZE_DIGITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       body_done_o,
  output logic [1:0] status_o
);

  chd_item_t   item;
  chd_q_stat_t q_stat;
  logic        q_full;
  logic        push;
  logic        pop;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  // Byte classification.
  chd_front u_front (
    .in_byte_i (in_byte_i),
    .item_o    (item)
  );

  // Decoupling queue between front and back.
  chd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (q_full),
    .pop_i  (pop),
    .stat_o (q_stat)
  );

  // Chunk parser and output register.
  chd_back #(
    .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .body_done_o (body_done_o),
    .status_o    (status_o)
  );

endmodule
